// ----- rtl/i2cm_pkg.sv -----
// shared types and constants of the i2c master bit engine
package i2cm_pkg;

  localparam int unsigned CmdDepthDefault = 2;
  localparam int unsigned ResDepthDefault = 2;
  localparam logic [15:0] AckTimeoutReset = 16'd1000;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_READ_ACK  = 3'd3,
    OP_READ_NACK = 3'd4
  } op_e;

  // input word as offered on the push side
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       sda_in;
  } cmd_t;

  // result word as shown on the pop side
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
    logic       error_flag;
  } res_t;

  // classified word handed from front to back
  typedef struct packed {
    logic       launch;
    op_e        op;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

endpackage

// ----- rtl/i2cm_fifo.sv -----
// small first-in first-out queue of words
module i2cm_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/i2cm_front.sv -----
// front end: accepts command words, classifies them and queues them for the engine
module i2cm_front import i2cm_pkg::*; #(
  parameter int unsigned CmdDepth = CmdDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  cmd_t  cmd_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_ready_i
);

  item_t item_in;
  logic  q_empty;

  // operation codes above read-with-nack never start anything
  always_comb begin
    item_in.launch  = cmd_i.cmd_valid && (cmd_i.operation <= 3'(OP_READ_NACK));
    item_in.op      = op_e'(cmd_i.operation);
    item_in.tx_byte = cmd_i.tx_byte;
    item_in.sda_in  = cmd_i.sda_in;
  end

  i2cm_fifo #(
    .Width ($bits(item_t)),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (full),
    .pop_i   (item_ready_i),
    .data_o  (item_o),
    .empty_o (q_empty)
  );

  assign item_valid_o = ~q_empty;

endmodule

// ----- rtl/i2cm_back.sv -----
// back end: bus sequencer, one drive step per word, results queued for the pop side
module i2cm_back import i2cm_pkg::*; #(
  parameter int unsigned ResDepth = ResDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_ready_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        empty,
  input  logic        pop,
  output res_t        res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_STOP,
    PH_WBIT,
    PH_WACK,
    PH_RBIT,
    PH_RACK
  } phase_e;

  phase_e      phase_q, phase_d, run_ph;
  logic [1:0]  sub_q, sub_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] wait_q, wait_d;
  op_e         op_q, op_d;
  logic        scl_q, scl_d, sda_q, sda_d, err_q, err_d, nack_q, nack_d;
  logic [15:0] timeout_q;
  logic        res_full, fire, done;
  res_t        res_d;

  assign fire         = item_valid_i & ~res_full;
  assign item_ready_o = ~res_full;

  always_comb begin
    phase_d = phase_q;
    sub_d   = sub_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    op_d    = op_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    err_d   = err_q;
    nack_d  = nack_q;
    done    = 1'b0;

    if (phase_q == PH_IDLE && item_i.launch) begin
      op_d   = item_i.op;
      sub_d  = 2'd0;
      bit_d  = 3'd0;
      wait_d = 16'd0;
      unique case (item_i.op)
        OP_START: begin
          phase_d = PH_START;
          err_d   = 1'b0;
        end
        OP_STOP: phase_d = PH_STOP;
        OP_WRITE: begin
          phase_d = PH_WBIT;
          shift_d = item_i.tx_byte;
        end
        default: begin
          phase_d = PH_RBIT;
          shift_d = 8'd0;
        end
      endcase
    end

    run_ph = phase_d;
    unique case (run_ph)
      PH_START: begin
        unique case (sub_d)
          2'd0: begin scl_d = 1'b1; sda_d = 1'b1; sub_d = 2'd1; end
          2'd1: begin scl_d = 1'b1; sda_d = 1'b0; sub_d = 2'd2; end
          default: begin scl_d = 1'b0; sda_d = 1'b0; done = 1'b1; end
        endcase
      end
      PH_STOP: begin
        unique case (sub_d)
          2'd0: begin scl_d = 1'b0; sda_d = 1'b0; sub_d = 2'd1; end
          2'd1: begin scl_d = 1'b1; sda_d = 1'b0; sub_d = 2'd2; end
          default: begin scl_d = 1'b1; sda_d = 1'b1; done = 1'b1; end
        endcase
      end
      PH_WBIT: begin
        sda_d = shift_d[7];
        if (sub_d == 2'd0) begin
          scl_d = 1'b0;
          sub_d = 2'd1;
        end else begin
          scl_d   = 1'b1;
          sub_d   = 2'd0;
          shift_d = {shift_d[6:0], 1'b0};
          if (bit_d == 3'd7) begin
            phase_d = PH_WACK;
            bit_d   = 3'd0;
          end else begin
            bit_d = bit_d + 1'b1;
          end
        end
      end
      PH_WACK: begin
        sda_d = 1'b1;
        if (sub_d == 2'd0) begin
          scl_d = 1'b0;
          sub_d = 2'd1;
        end else if (sub_d == 2'd1) begin
          scl_d  = 1'b1;
          sub_d  = 2'd2;
          wait_d = 16'd0;
        end else if (!item_i.sda_in) begin
          scl_d  = 1'b0;
          nack_d = 1'b0;
          done   = 1'b1;
        end else if (wait_d >= timeout_q) begin
          // slave never pulled sda low in time
          scl_d  = 1'b0;
          nack_d = 1'b1;
          err_d  = 1'b1;
          done   = 1'b1;
        end else begin
          wait_d = wait_d + 1'b1;
          scl_d  = 1'b1;
        end
      end
      PH_RBIT: begin
        sda_d = 1'b1;
        if (sub_d == 2'd0) begin
          scl_d = 1'b1;
          sub_d = 2'd1;
        end else begin
          shift_d = {shift_d[6:0], item_i.sda_in};
          scl_d   = 1'b0;
          sub_d   = 2'd0;
          if (bit_d == 3'd7) begin
            phase_d = PH_RACK;
            bit_d   = 3'd0;
          end else begin
            bit_d = bit_d + 1'b1;
          end
        end
      end
      PH_RACK: begin
        if (op_d == OP_READ_ACK) begin
          unique case (sub_d)
            2'd0: begin scl_d = 1'b0; sda_d = 1'b0; sub_d = 2'd1; end
            2'd1: begin scl_d = 1'b1; sda_d = 1'b0; sub_d = 2'd2; end
            2'd2: begin scl_d = 1'b0; sda_d = 1'b0; sub_d = 2'd3; end
            default: begin scl_d = 1'b0; sda_d = 1'b1; done = 1'b1; end
          endcase
        end else begin
          unique case (sub_d)
            2'd0: begin scl_d = 1'b0; sda_d = 1'b1; sub_d = 2'd1; end
            2'd1: begin scl_d = 1'b1; sda_d = 1'b1; sub_d = 2'd2; end
            default: begin scl_d = 1'b0; sda_d = 1'b1; done = 1'b1; end
          endcase
        end
      end
      default: ;
    endcase

    res_d.rx_byte = 8'd0;
    if (done) begin
      if (op_d == OP_READ_ACK || op_d == OP_READ_NACK) begin
        res_d.rx_byte = shift_d;
      end
      phase_d = PH_IDLE;
      sub_d   = 2'd0;
      bit_d   = 3'd0;
    end

    res_d.scl_level  = scl_d;
    res_d.sda_level  = sda_d;
    res_d.busy_res   = (phase_q != PH_IDLE);
    res_d.done_res   = done;
    res_d.nack       = nack_d;
    res_d.error_flag = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      sub_q     <= 2'd0;
      bit_q     <= 3'd0;
      shift_q   <= 8'd0;
      wait_q    <= 16'd0;
      op_q      <= OP_START;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      err_q     <= 1'b0;
      nack_q    <= 1'b0;
      timeout_q <= AckTimeoutReset;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        sub_q   <= sub_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        wait_q  <= wait_d;
        op_q    <= op_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        err_q   <= err_d;
        nack_q  <= nack_d;
      end
    end
  end

  i2cm_fifo #(
    .Width ($bits(res_t)),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

endmodule

// ----- rtl/i2c_master_bit_engine.sv -----
// i2c master bit engine: one bus tick per word, drive levels and status per word
// a pushed word waits in the command queue; its result goes to the result queue for the pop side
// throughput: one word per cycle unless the result queue is full (single-step back end)
// both sides are queues (default depth two), so either side may stall on its own
// reset: queues empty, scl and sda released high, flags clear, ack timeout 1000 ticks
module i2c_master_bit_engine import i2cm_pkg::*; #(
  parameter int unsigned CmdDepth = CmdDepthDefault,
  parameter int unsigned ResDepth = ResDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  cmd_t        cmd_i,
  output logic        empty,
  input  logic        pop,
  output res_t        res_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic  item_valid, item_ready;
  item_t item;

  i2cm_front #(
    .CmdDepth (CmdDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  i2cm_back #(
    .ResDepth (ResDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res_o)
  );

endmodule

// ----- rtl/i2cm_checker.sv -----
// port-level checks of the i2c master bit engine and their binding
module i2cm_checker import i2cm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input res_t res_o
);

  // a command can only finish on a tick that found the engine busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.done_res) |-> res_o.busy_res)
    else $error("done without busy");

  // received data shows only on the finishing tick
  a_rx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.done_res) |-> (res_o.rx_byte == 8'd0))
    else $error("rx byte outside done");

  // a word not taken stays put
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("waiting result changed");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);
